[sv/hrv_pkg.sv]
// Shared types and constants for the HDCP repeater V SHA-1 block.
package hrv_pkg;

	typedef struct packed {
		logic        operation;
		logic [39:0] ksv;
		logic [15:0] bstatus;
		logic [63:0] m0;
	} in_word_t;

	typedef struct packed {
		logic [31:0] v_word;
		logic [2:0]  word_index;
		logic        last;
		logic        status;
	} out_word_t;

	localparam logic OP_KSV    = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [159:0] SHA_INIT =
		160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

endpackage

[sv/hrv_round.sv]
// SHA-1 core: one round per cycle over a 16-word schedule window.
module hrv_round (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         init,
	input  logic [511:0] block,
	output logic         busy,
	output logic [159:0] digest
);
	import hrv_pkg::*;

	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [159:0] h_q;
	logic [6:0]   rnd_q;
	logic         busy_q;
	logic [31:0]  f, k, t, wn;

	assign busy   = busy_q;
	assign digest = h_q;

	// Select round function and constant
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
		end
		t  = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		wn = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wn = {wn[30:0], wn[31]};
	end

	// Run rounds, then fold into chain value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			h_q    <= SHA_INIT;
		end else if (init) begin
			h_q <= SHA_INIT;
		end else if (start) begin
			busy_q <= 1'b1;
			rnd_q  <= '0;
			{a_q, b_q, c_q, d_q, e_q} <= h_q;
			for (int i = 0; i < 16; i++) w_q[i] <= block[511-32*i -: 32];
		end else if (busy_q) begin
			if (rnd_q == 7'd80) begin
				busy_q <= 1'b0;
				h_q <= {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
					h_q[63:32] + d_q, h_q[31:0] + e_q};
			end else begin
				rnd_q <= rnd_q + 7'd1;
				{a_q, b_q, c_q, d_q, e_q} <= {t, a_q, {b_q[1:0], b_q[31:2]}, c_q, d_q};
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= wn;
			end
		end
	end
endmodule

[sv/hdcp_repeater_v_sha1.sv]
// Top level: byte sequencer, padding and output for HDCP repeater V.
// An append below the device limit feeds its five KSV bytes, and runs a block when it fills one.
// A finish feeds 10 bytes, pads one byte per cycle, runs one or two blocks and then
// emits five digest words.
// Input stall is high while an item is in work or the digest is pending.
// Reset clears the chain value, counters and the byte-order register rev_q.
module hdcp_repeater_v_sha1 #(
	parameter int MAX_DEVICES = 127
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  hrv_pkg::in_word_t  in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output hrv_pkg::out_word_t out_data
);
	import hrv_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0, ST_FEED = 3'd1, ST_HASH = 3'd2,
		ST_PAD = 3'd3, ST_OUT = 3'd4;

	logic [2:0]   st_q;
	logic         rev_q;
	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [9:0]   mbytes_q;
	logic [6:0]   dev_q;
	logic         ovf_q;
	logic [79:0]  val_q;
	logic [3:0]   nb_q, bi_q;
	logic         fin_q;
	logic         pad_len_q;
	logic [2:0]   oi_q;
	logic         rstart_q, rinit_q, rbusy;
	logic [159:0] digest;
	logic [7:0]   byte_v, pad_b;
	logic [63:0]  bitlen;
	logic [3:0]   pos;

	hrv_round u_round (.clk, .arst_n, .start(rstart_q), .init(rinit_q), .block(blk_q),
		.busy(rbusy), .digest);

	assign pos    = rev_q ? (nb_q - 4'd1 - bi_q) : bi_q;
	assign byte_v = val_q[{pos[3:0], 3'b000} +: 8];
	assign bitlen = {51'd0, mbytes_q, 3'b000};
	// Zero fill, or the length when it belongs in this block
	always_comb begin
		if (fill_q < 6'd56 || !pad_len_q) pad_b = 8'h00;
		else pad_b = bitlen[8*(6'd63 - fill_q) +: 8];
	end

	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign out_data  = '{v_word: digest[159-32*oi_q -: 32], word_index: oi_q,
		last: (oi_q == 3'd4), status: ovf_q};

	// Sequence bytes into the block and drive the core
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; rev_q <= 1'b0; fill_q <= '0; mbytes_q <= '0;
			dev_q <= '0; ovf_q <= 1'b0; rstart_q <= 1'b0; rinit_q <= 1'b0;
			fin_q <= 1'b0; oi_q <= '0; bi_q <= '0; nb_q <= '0; pad_len_q <= 1'b0;
		end else begin
			rstart_q <= 1'b0;
			rinit_q  <= 1'b0;
			if (cfg_we) rev_q <= cfg_wdata;
			unique case (st_q)
				ST_IDLE: if (in_valid) begin
					bi_q <= '0;
					if (in_data.operation == OP_FINISH) begin
						fin_q <= 1'b1; nb_q <= 4'd2;
						val_q <= {in_data.m0, in_data.bstatus};
						st_q <= ST_FEED;
					end else if (dev_q < 7'(MAX_DEVICES)) begin
						fin_q <= 1'b0; nb_q <= 4'd5; dev_q <= dev_q + 7'd1;
						val_q <= {40'd0, in_data.ksv};
						st_q <= ST_FEED;
					end else ovf_q <= 1'b1;
				end
				ST_FEED: begin
					blk_q <= {blk_q[503:0], byte_v};
					fill_q <= fill_q + 6'd1;
					mbytes_q <= mbytes_q + 10'd1;
					if (bi_q == nb_q - 4'd1) begin
						bi_q <= '0;
						if (fin_q && nb_q == 4'd2) begin
							nb_q <= 4'd8; val_q <= {16'd0, val_q[79:16]};
						end else if (fin_q) nb_q <= 4'd0;
						else nb_q <= 4'd5;
					end else bi_q <= bi_q + 4'd1;
					if (fill_q == 6'd63) begin
						rstart_q <= 1'b1; st_q <= ST_HASH;
					end else if (bi_q == nb_q - 4'd1 && !(fin_q && nb_q == 4'd2))
						st_q <= fin_q ? ST_PAD : ST_IDLE;
				end
				// Resume a value cut by the block end, else move on
				ST_HASH: if (!rstart_q && !rbusy) begin
					if (!fin_q) st_q <= (bi_q != 4'd0) ? ST_FEED : ST_IDLE;
					else if (nb_q != 4'd0) st_q <= ST_FEED;
					else if (bi_q == 4'd1) begin
						st_q <= ST_OUT; oi_q <= '0;
					end else begin
						st_q <= ST_PAD; pad_len_q <= 1'b1;
					end
				end
				ST_PAD: begin
					blk_q <= {blk_q[503:0], ((bi_q == 4'd0) ? 8'h80 : pad_b)};
					if (bi_q == 4'd0) begin
						bi_q <= 4'd2; pad_len_q <= (fill_q < 6'd56);
					end
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						rstart_q <= 1'b1; st_q <= ST_HASH;
						// A block that carried the length is the last one
						if (bi_q != 4'd0 && pad_len_q) bi_q <= 4'd1;
					end
				end
				ST_OUT: if (!out_stall) begin
					if (oi_q == 3'd4) begin
						st_q <= ST_IDLE; rinit_q <= 1'b1; fill_q <= '0;
						mbytes_q <= '0; dev_q <= '0; ovf_q <= 1'b0;
					end else oi_q <= oi_q + 3'd1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Checks on sequencer and core
	a_no_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !rbusy) else $error("digest shown while core busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rstart_q |=> rbusy) else $error("core did not start");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> oi_q <= 3'd4) else $error("bad word index");
endmodule

[sim/hdcp_repeater_v_sha1_test.sv]
// Testbench for the HDCP repeater V SHA-1 block: directed and random KSV lists with digest checks.
module hdcp_repeater_v_sha1_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hrv_pkg::*;

	localparam int MAX_DEV = 127;
	localparam int QUIET_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;

	hdcp_repeater_v_sha1 #(.MAX_DEVICES(MAX_DEV)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// predictor state
	logic [31:0] hash_state [5];
	logic [7:0]  msg_block [64];
	int unsigned blk_fill;
	logic [9:0]  msg_len;
	int unsigned ksv_count;
	logic        too_many;
	logic        rev_order;

	out_word_t digest_q [$];
	int unsigned fail_count;
	int unsigned accept_quiet;
	int unsigned words_seen;
	int unsigned messages_sent;
	bit          idle_enable;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] rotl32(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// Run one SHA-1 compression over the current block.
	task automatic sha_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
		d = hash_state[3]; e = hash_state[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rotl32(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rotl32(b, 30); b = a; a = t;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
		hash_state[3] += d; hash_state[4] += e;
	endtask

	task automatic push_byte(logic [7:0] byt, bit counted);
		msg_block[blk_fill] = byt;
		blk_fill++;
		if (blk_fill == 64) begin
			sha_compress();
			blk_fill = 0;
		end
		if (counted)
			msg_len++;
	endtask

	task automatic push_value(logic [63:0] val, int nbytes);
		int pos;
		for (int i = 0; i < nbytes; i++) begin
			pos = rev_order ? (nbytes - 1 - i) : i;
			push_byte(val[8*pos +: 8], 1'b1);
		end
	endtask

	task automatic clear_digest_state();
		for (int i = 0; i < 5; i++)
			hash_state[i] = SHA_INIT[159 - 32*i -: 32];
		blk_fill = 0;
		msg_len = '0;
		ksv_count = 0;
		too_many = 1'b0;
	endtask

	// Work out the digest words that one accepted word produces.
	task automatic predict_digest(in_word_t wd);
		logic [63:0] bit_len;
		out_word_t r;
		if (wd.operation == OP_KSV) begin
			if (ksv_count < MAX_DEV) begin
				push_value({24'd0, wd.ksv}, 5);
				ksv_count++;
			end else begin
				too_many = 1'b1;
			end
			return;
		end
		push_value({48'd0, wd.bstatus}, 2);
		push_value(wd.m0, 8);
		bit_len = 64'(msg_len) * 8;
		push_byte(8'h80, 1'b0);
		while (blk_fill != 56)
			push_byte(8'h00, 1'b0);
		for (int i = 0; i < 8; i++)
			push_byte(bit_len[63 - 8*i -: 8], 1'b0);
		for (int i = 0; i < 5; i++) begin
			r.v_word = hash_state[i];
			r.word_index = 3'(i);
			r.last = (i == 4);
			r.status = too_many;
			digest_q.push_back(r);
		end
		clear_digest_state();
	endtask

	// Hold the word until accepted, then predict; valid stays up for the next word.
	task automatic send_word(in_word_t wd);
		while (idle_enable && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= wd;
		do
			@(posedge clk);
		while (in_stall);
		predict_digest(wd);
		@(negedge clk);
	endtask

	task automatic send_ksv(logic [39:0] v);
		in_word_t wd;
		wd = '0;
		wd.operation = OP_KSV;
		wd.ksv = v;
		send_word(wd);
	endtask

	task automatic send_finish(logic [15:0] bs, logic [63:0] m);
		in_word_t wd;
		wd = '0;
		wd.operation = OP_FINISH;
		wd.bstatus = bs;
		wd.m0 = m;
		send_word(wd);
		messages_sent++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [39:0] rand_ksv();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return {8'($urandom), $urandom};
		endcase
	endfunction

	// Drain the outstanding digest, then write the byte order register.
	task automatic set_byte_order(logic val);
		in_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		rev_order = val;
	endtask

	task automatic test_directed();
		idle_enable = 1'b0;
		send_finish(16'h0000, 64'h0);
		send_finish(16'hFFFF, '1);
		send_ksv('0);
		send_ksv('1);
		send_ksv(40'h01_2345_6789);
		send_finish(16'h1234, 64'h0123_4567_89AB_CDEF);
		// eleven KSVs and the finish bytes make the data cross a block boundary
		for (int i = 0; i < 11; i++)
			send_ksv(rand_ksv());
		send_finish(16'($urandom), rand64());
		idle_enable = 1'b1;
	endtask

	task automatic test_byte_order();
		set_byte_order(1'b1);
		for (int i = 0; i < 3; i++)
			send_ksv(rand_ksv());
		send_finish(16'hA55A, 64'h8000_0000_0000_0001);
		set_byte_order(1'b0);
	endtask

	// Send two words past the device limit so the extra KSVs are dropped.
	task automatic test_overflow();
		for (int i = 0; i < MAX_DEV + 2; i++)
			send_ksv(rand_ksv());
		send_finish(16'($urandom), rand64());
	endtask

	task automatic test_random();
		int sent;
		int n;
		sent = 0;
		while (sent < 80) begin
			if ($urandom_range(9) == 0)
				set_byte_order(1'($urandom));
			n = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(5);
			for (int i = 0; i < n; i++)
				send_ksv(rand_ksv());
			send_finish(16'($urandom), rand64());
			sent += n + 1;
		end
	endtask

	// Stall the output side at random, with a quiet stretch.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= idle_enable && ($urandom_range(99) < 13);
		end
	end

	// Compare each digest word with the oldest expected one.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			words_seen++;
			if (digest_q.size() == 0) begin
				$error("unexpected digest word %h", out_data);
				fail_count++;
			end else begin
				want = digest_q.pop_front();
				if (out_data.v_word !== want.v_word) begin
					$error("v_word expected %h got %h", want.v_word, out_data.v_word);
					fail_count++;
				end
				if (out_data.word_index !== want.word_index) begin
					$error("word_index expected %0d got %0d", want.word_index,
						out_data.word_index);
					fail_count++;
				end
				if (out_data.last !== want.last) begin
					$error("last expected %b got %b", want.last, out_data.last);
					fail_count++;
				end
				if (out_data.status !== want.status) begin
					$error("status expected %b got %b", want.status, out_data.status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run after a long stretch with no handshake.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			accept_quiet <= 0;
		else
			accept_quiet <= accept_quiet + 1;
		if (accept_quiet >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		accept_quiet = 0;
		words_seen = 0;
		messages_sent = 0;
		idle_enable = 1'b0;
		rev_order = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		clear_digest_state();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		set_byte_order(1'b0);
		test_directed();
		test_byte_order();
		test_overflow();
		test_random();
		set_byte_order(1'b1);
		test_random();
		in_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
		$display("Hashed %0d messages, %0d digest words checked,", messages_sent, words_seen);
		$display("both byte orders, empty lists and a list past the device limit.");
		if (fail_count == 0 && digest_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
